// ===== hw/rtl/piddb_pkg.sv =====
// Shared types, widths, register codes and helpers of the deadband PID controller.
package piddb_pkg;

  // Default number of fraction bits of the gain registers.
  localparam int unsigned FRAC_BITS_DEF = 12;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned DEADBAND_W = 15;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned MODE_W     = 5;
  localparam int unsigned ERR_W      = SAMPLE_W + 1;
  localparam int unsigned TOTAL_W    = 32;

  // Gains are widened by one bit so that a negated minimum still fits.
  localparam int unsigned GAINX_W    = GAIN_W + 1;
  localparam int unsigned PROD_W     = GAINX_W + ERR_W;
  localparam int unsigned IPROD_W    = GAINX_W + TOTAL_W;
  localparam int unsigned PD_W       = PROD_W + 1;
  localparam int unsigned SUM_W      = PD_W + 1;

  // Configuration port.
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned IDX_W      = 3;

  // Mode bit positions.
  localparam int unsigned MODE_P     = 0;
  localparam int unsigned MODE_I     = 1;
  localparam int unsigned MODE_D     = 2;
  localparam int unsigned MODE_AUTO  = 3;
  localparam int unsigned MODE_REV   = 4;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0]   SETPOINT_RST  = 16'd0;
  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST = 24'd4096;
  localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST = 24'd410;
  localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST = 24'd0;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 15'd0;
  localparam logic [DRIVE_W-1:0]    DRIVE_MIN_RST = 16'd0;
  localparam logic [DRIVE_W-1:0]    DRIVE_MAX_RST = 16'd255;
  localparam logic [MODE_W-1:0]     MODE_RST      = 5'd7;

  // Register indexes; byte address is four times the index.
  typedef enum logic [IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_DERIV_GAIN = 3'd3,
    REG_DEADBAND   = 3'd4,
    REG_DRIVE_MIN  = 3'd5,
    REG_DRIVE_MAX  = 3'd6,
    REG_MODE       = 3'd7
  } reg_idx_t;

  // Current register contents, shared by all stages.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]   prop_gain;
    logic signed [GAIN_W-1:0]   integ_gain;
    logic signed [GAIN_W-1:0]   deriv_gain;
    logic [DEADBAND_W-1:0]      deadband;
    logic signed [DRIVE_W-1:0]  drive_min;
    logic signed [DRIVE_W-1:0]  drive_max;
    logic [MODE_W-1:0]          mode_bits;
  } cfg_t;

  // Error stage result.
  typedef struct packed {
    logic                       manual;
    logic                       dead;
    logic                       flip;
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W-1:0]    dsample;
    logic signed [TOTAL_W-1:0]  total;
  } front_t;

  // Product stage result.
  typedef struct packed {
    logic                       manual;
    logic                       dead;
    logic                       flip;
    logic signed [PROD_W-1:0]   p_prod;
    logic signed [PROD_W-1:0]   d_prod;
    logic signed [IPROD_W-1:0]  i_prod;
  } mult_t;

  // Clamp a wide value to [lo, hi]; above hi wins over below lo.
  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [SUM_W-1:0]   v,
    input logic signed [DRIVE_W-1:0] lo,
    input logic signed [DRIVE_W-1:0] hi
  );
    logic signed [SUM_W-1:0]   lo_x;
    logic signed [SUM_W-1:0]   hi_x;
    logic signed [DRIVE_W-1:0] res;
    lo_x = $signed({{(SUM_W-DRIVE_W){lo[DRIVE_W-1]}}, lo});
    hi_x = $signed({{(SUM_W-DRIVE_W){hi[DRIVE_W-1]}}, hi});
    if (v > hi_x) begin
      res = hi;
    end else if (v < lo_x) begin
      res = lo;
    end else begin
      res = $signed(v[DRIVE_W-1:0]);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/piddb_if.sv =====
// Valid/ready channel interfaces for samples in and drive values out.
interface piddb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [piddb_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface piddb_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [piddb_pkg::DRIVE_W-1:0]   drive;
  logic                                   computed;

  modport source (output valid, output drive, output computed, input ready);
  modport sink   (input valid, input drive, input computed, output ready);
endinterface

// ===== hw/rtl/piddb_cfg.sv =====
// APB-style register file holding setpoint, gains, limits and mode.
module piddb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [piddb_pkg::PADDR_W-1:0] paddr,
  input  logic [piddb_pkg::PDATA_W-1:0] pwdata,
  output logic [piddb_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output piddb_pkg::cfg_t               cfg
);
  import piddb_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint   <= SETPOINT_RST;
      cfg_r.prop_gain  <= PROP_GAIN_RST;
      cfg_r.integ_gain <= INTEG_GAIN_RST;
      cfg_r.deriv_gain <= DERIV_GAIN_RST;
      cfg_r.deadband   <= DEADBAND_RST;
      cfg_r.drive_min  <= DRIVE_MIN_RST;
      cfg_r.drive_max  <= DRIVE_MAX_RST;
      cfg_r.mode_bits  <= MODE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SETPOINT:   cfg_r.setpoint   <= pwdata[SAMPLE_W-1:0];
        REG_PROP_GAIN:  cfg_r.prop_gain  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg_r.integ_gain <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg_r.deriv_gain <= pwdata[GAIN_W-1:0];
        REG_DEADBAND:   cfg_r.deadband   <= pwdata[DEADBAND_W-1:0];
        REG_DRIVE_MIN:  cfg_r.drive_min  <= pwdata[DRIVE_W-1:0];
        REG_DRIVE_MAX:  cfg_r.drive_max  <= pwdata[DRIVE_W-1:0];
        REG_MODE:       cfg_r.mode_bits  <= pwdata[MODE_W-1:0];
      endcase
    end
  end

  // Read data, zero-extended raw register bits.
  always_comb begin
    unique case (idx)
      REG_SETPOINT:   prdata = {{(PDATA_W-SAMPLE_W){1'b0}}, cfg_r.setpoint};
      REG_PROP_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, cfg_r.prop_gain};
      REG_INTEG_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, cfg_r.integ_gain};
      REG_DERIV_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, cfg_r.deriv_gain};
      REG_DEADBAND:   prdata = PDATA_W'(cfg_r.deadband);
      REG_DRIVE_MIN:  prdata = {{(PDATA_W-DRIVE_W){1'b0}}, cfg_r.drive_min};
      REG_DRIVE_MAX:  prdata = {{(PDATA_W-DRIVE_W){1'b0}}, cfg_r.drive_max};
      REG_MODE:       prdata = PDATA_W'(cfg_r.mode_bits);
    endcase
  end

endmodule

// ===== hw/rtl/piddb_front.sv =====
// Input register and error stage: error, deadband test, saturating total, sign change.
module piddb_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  piddb_pkg::cfg_t                       cfg,
  input  logic                                  up_vld,
  input  logic signed [piddb_pkg::SAMPLE_W-1:0] up_sample,
  output logic                                  up_rdy,
  output logic                                  dn_vld,
  output piddb_pkg::front_t                     dn_data,
  input  logic                                  dn_rdy
);
  import piddb_pkg::*;

  logic                       s0_vld_r;
  logic signed [SAMPLE_W-1:0] s0_sample_r;
  logic                       s1_vld_r;
  front_t                     s1_r;

  logic signed [SAMPLE_W-1:0] prev_sample_r;
  logic signed [ERR_W-1:0]    prev_err_r;
  logic signed [TOTAL_W-1:0]  total_r;

  logic                       s1_rdy;
  logic                       s0_fire;
  logic                       manual;
  logic signed [ERR_W-1:0]    err;
  logic [ERR_W-1:0]           aerr;
  logic                       dead;
  logic signed [ERR_W-1:0]    dsample;
  logic signed [TOTAL_W:0]    sum_w;
  logic signed [TOTAL_W-1:0]  sat;
  logic                       flip;
  logic signed [TOTAL_W-1:0]  total_nxt;
  front_t                     s1_nxt;

  // Stage handshake: a stage moves when the one after it has room.
  assign s1_rdy  = !s1_vld_r || dn_rdy;
  assign s0_fire = s0_vld_r && s1_rdy;
  assign up_rdy  = !s0_vld_r || s1_rdy;
  assign dn_vld  = s1_vld_r;
  assign dn_data = s1_r;

  // Error, deadband and saturating accumulation.
  always_comb begin
    manual  = !cfg.mode_bits[MODE_AUTO];
    err     = $signed({cfg.setpoint[SAMPLE_W-1], cfg.setpoint})
            - $signed({s0_sample_r[SAMPLE_W-1], s0_sample_r});
    aerr    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    dead    = aerr < {{(ERR_W-DEADBAND_W){1'b0}}, cfg.deadband};
    dsample = $signed({s0_sample_r[SAMPLE_W-1], s0_sample_r})
            - $signed({prev_sample_r[SAMPLE_W-1], prev_sample_r});
    sum_w   = $signed({total_r[TOTAL_W-1], total_r})
            + $signed({{(TOTAL_W+1-ERR_W){err[ERR_W-1]}}, err});
    if (sum_w[TOTAL_W] != sum_w[TOTAL_W-1]) begin
      sat = sum_w[TOTAL_W] ? $signed({1'b1, {(TOTAL_W-1){1'b0}}})
                           : $signed({1'b0, {(TOTAL_W-1){1'b1}}});
    end else begin
      sat = $signed(sum_w[TOTAL_W-1:0]);
    end
    // Strictly opposite signs, or a zero error after a negative one.
    flip = (prev_err_r[ERR_W-1] && !err[ERR_W-1] && (err != '0))
        || (!prev_err_r[ERR_W-1] && (prev_err_r != '0) && err[ERR_W-1])
        || ((err == '0) && prev_err_r[ERR_W-1]);
    total_nxt = flip ? '0 : sat;

    s1_nxt.manual  = manual;
    s1_nxt.dead    = dead;
    s1_nxt.flip    = flip;
    s1_nxt.err     = err;
    s1_nxt.dsample = dsample;
    s1_nxt.total   = total_nxt;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (up_rdy) begin
      s0_vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_vld && up_rdy) begin
      s0_sample_r <= up_sample;
    end
  end

  // Error stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // Controller history, updated once per transfer outside manual mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_err_r    <= '0;
      total_r       <= '0;
    end else if (s0_fire && !manual) begin
      if (dead) begin
        total_r <= '0;
      end else begin
        total_r       <= total_nxt;
        prev_err_r    <= err;
        prev_sample_r <= s0_sample_r;
      end
    end
  end

endmodule

// ===== hw/rtl/piddb_mult.sv =====
// Product stage: P, D and integral gains times error, sample change and total.
module piddb_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  piddb_pkg::cfg_t   cfg,
  input  logic              up_vld,
  input  piddb_pkg::front_t up_data,
  output logic              up_rdy,
  output logic              dn_vld,
  output piddb_pkg::mult_t  dn_data,
  input  logic              dn_rdy
);
  import piddb_pkg::*;

  logic                      vld_r;
  mult_t                     data_r;
  logic signed [GAINX_W-1:0] kp;
  logic signed [GAINX_W-1:0] ki;
  logic signed [GAINX_W-1:0] kd;
  mult_t                     data_nxt;

  assign up_rdy  = !vld_r || dn_rdy;
  assign dn_vld  = vld_r;
  assign dn_data = data_r;

  // Widen the gains and flip them for reverse action, then multiply.
  always_comb begin
    kp = $signed({cfg.prop_gain[GAIN_W-1], cfg.prop_gain});
    ki = $signed({cfg.integ_gain[GAIN_W-1], cfg.integ_gain});
    kd = $signed({cfg.deriv_gain[GAIN_W-1], cfg.deriv_gain});
    if (cfg.mode_bits[MODE_REV]) begin
      kp = -kp;
      ki = -ki;
      kd = -kd;
    end
    data_nxt.manual = up_data.manual;
    data_nxt.dead   = up_data.dead;
    data_nxt.flip   = up_data.flip;
    // Disabled P and D terms contribute zero; the products stay signed.
    data_nxt.p_prod = '0;
    data_nxt.d_prod = '0;
    if (cfg.mode_bits[MODE_P]) begin
      data_nxt.p_prod = kp * $signed(up_data.err);
    end
    if (cfg.mode_bits[MODE_D]) begin
      data_nxt.d_prod = kd * $signed(up_data.dsample);
    end
    data_nxt.i_prod = ki * $signed(up_data.total);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_vld && up_rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hw/rtl/piddb_back.sv =====
// Output stage: integral term, term sum, clamping and the result register.
module piddb_back #(
  parameter int unsigned FRAC_BITS = piddb_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  piddb_pkg::cfg_t                      cfg,
  input  logic                                 up_vld,
  input  piddb_pkg::mult_t                     up_data,
  output logic                                 up_rdy,
  output logic                                 dn_vld,
  output logic signed [piddb_pkg::DRIVE_W-1:0] dn_drive,
  output logic                                 dn_computed,
  input  logic                                 dn_rdy
);
  import piddb_pkg::*;

  logic                      vld_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      computed_r;
  logic signed [DRIVE_W-1:0] integ_r;
  logic signed [DRIVE_W-1:0] held_r;

  logic                      fire;
  logic signed [PD_W-1:0]    pd;
  logic signed [PD_W-1:0]    pd_sh;
  logic signed [IPROD_W-1:0] i_sh;
  logic signed [DRIVE_W-1:0] i_sat;
  logic signed [DRIVE_W-1:0] i_base;
  logic signed [DRIVE_W-1:0] i_lim;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [DRIVE_W-1:0] drive_nxt;
  logic                      computed_nxt;

  assign up_rdy      = !vld_r || dn_rdy;
  assign fire        = up_vld && up_rdy;
  assign dn_vld      = vld_r;
  assign dn_drive    = drive_r;
  assign dn_computed = computed_r;

  // Integral term and clamped drive value.
  always_comb begin
    pd    = $signed({up_data.p_prod[PROD_W-1], up_data.p_prod})
          - $signed({up_data.d_prod[PROD_W-1], up_data.d_prod});
    pd_sh = pd >>> FRAC_BITS;
    i_sh  = $signed(up_data.i_prod) >>> FRAC_BITS;
    // Saturate the integral to the 16-bit range.
    if (i_sh[IPROD_W-1:DRIVE_W-1] != {(IPROD_W-DRIVE_W+1){i_sh[IPROD_W-1]}}) begin
      i_sat = i_sh[IPROD_W-1] ? $signed({1'b1, {(DRIVE_W-1){1'b0}}})
                              : $signed({1'b0, {(DRIVE_W-1){1'b1}}});
    end else begin
      i_sat = $signed(i_sh[DRIVE_W-1:0]);
    end
    if (up_data.flip) begin
      i_base = '0;
    end else if (cfg.mode_bits[MODE_I]) begin
      i_base = i_sat;
    end else begin
      i_base = integ_r;
    end
    i_lim = clamp_drive($signed({{(SUM_W-DRIVE_W){i_base[DRIVE_W-1]}}, i_base}),
                        cfg.drive_min, cfg.drive_max);
    sum   = $signed({pd_sh[PD_W-1], pd_sh})
          + $signed({{(SUM_W-DRIVE_W){i_lim[DRIVE_W-1]}}, i_lim});
    drive = clamp_drive(sum, cfg.drive_min, cfg.drive_max);

    // Result selection by mode.
    if (up_data.manual) begin
      drive_nxt    = '0;
      computed_nxt = 1'b0;
    end else if (up_data.dead) begin
      drive_nxt    = held_r;
      computed_nxt = 1'b1;
    end else begin
      drive_nxt    = drive;
      computed_nxt = 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r    <= drive_nxt;
      computed_r <= computed_nxt;
    end
  end

  // Integral and held drive, updated once per transfer outside manual mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      held_r  <= '0;
    end else if (fire && !up_data.manual) begin
      if (up_data.dead) begin
        integ_r <= '0;
      end else begin
        integ_r <= i_lim;
        held_r  <= drive;
      end
    end
  end

endmodule

// ===== hw/rtl/pid_with_deadband_and_sign_reset.sv =====
// Top level of the PID controller with deadband and sign-change integral reset.
//
// One measured sample enters per transfer on in_ch; one result leaves per
// transfer on out_ch: a clamped drive value and a computed flag that is low
// in manual mode. Setpoint, gains, deadband, limits and mode are written
// through the APB-style cfg_ port; the user must do so only while no sample
// is in flight; the block itself does not enforce it. It is a four-register
// pipeline: input register, error stage, product stage (three parallel
// multipliers) and result register. A new sample is taken in every cycle
// unless a stalled receiver has filled the pipeline, so throughput is one
// sample per cycle. Controller history (previous sample and error, error
// total) updates in the error stage and the integral and held drive in the
// output stage, so back-to-back samples see each other exactly in order.
// A synchronous reset empties the pipeline, clears the history and loads
// the register defaults. When the receiver stalls, each stage holds its item
// and empty stages keep filling, so up to four samples are taken before
// in_ch.ready falls.
module pid_with_deadband_and_sign_reset #(
  parameter int unsigned FRAC_BITS = piddb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  piddb_in_if.sink                      in_ch,
  piddb_out_if.source                   out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [piddb_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [piddb_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [piddb_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import piddb_pkg::*;

  cfg_t   cfg;
  logic   fr_vld;
  front_t fr_data;
  logic   fr_rdy;
  logic   mu_vld;
  mult_t  mu_data;
  logic   mu_rdy;

  // Register file.
  piddb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input register and error stage.
  piddb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_vld    (in_ch.valid),
    .up_sample (in_ch.sample),
    .up_rdy    (in_ch.ready),
    .dn_vld    (fr_vld),
    .dn_data   (fr_data),
    .dn_rdy    (fr_rdy)
  );

  // Product stage.
  piddb_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .up_vld  (fr_vld),
    .up_data (fr_data),
    .up_rdy  (fr_rdy),
    .dn_vld  (mu_vld),
    .dn_data (mu_data),
    .dn_rdy  (mu_rdy)
  );

  // Output stage and result register.
  piddb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .up_vld      (mu_vld),
    .up_data     (mu_data),
    .up_rdy      (mu_rdy),
    .dn_vld      (out_ch.valid),
    .dn_drive    (out_ch.drive),
    .dn_computed (out_ch.computed),
    .dn_rdy      (out_ch.ready)
  );

endmodule
